[rtl/ptph_pkg.sv]
// ----------------------------------------------------------------------------
// ptph_pkg: shared types and constants for the profile tag parser
// character codes, line parser phases and the result beat layout
// ----------------------------------------------------------------------------
package ptph_pkg;

    localparam int CHAR_W      = 8;
    localparam int HASH_W      = 32;
    localparam int FIELD12_W   = 12;
    localparam int LINE_W      = 32;
    localparam int OUT_DATA_W  = 104;   // 100 bits of fields, padded to bytes

    localparam logic [CHAR_W-1:0] PIPE_CHAR  = 8'h7C;
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
    localparam logic [CHAR_W-1:0] DIGIT_0    = 8'h30;
    localparam logic [CHAR_W-1:0] DIGIT_9    = 8'h39;

    localparam logic [31:0] FIELD12_MAX = 32'd4095;

    // line number parser phase
    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_DONE   = 4'b1000
    } line_phase_t;

    // one result beat, tag_hash in the lowest bits and the pad in the highest
    typedef struct packed {
        logic [OUT_DATA_W-101:0]    pad;
        logic [FIELD12_W-1:0]       name_len;
        logic [FIELD12_W-1:0]       name_offset;
        logic signed [LINE_W-1:0]   line_value;
        logic [FIELD12_W-1:0]       file_len;
        logic [HASH_W-1:0]          tag_hash;
    } result_t;

    // saturate a count into a 12-bit field
    function automatic logic [FIELD12_W-1:0] clamp12(input logic [31:0] v);
        logic [31:0] r;
        begin
            r = (v > FIELD12_MAX) ? FIELD12_MAX : v;
            clamp12 = r[FIELD12_W-1:0];
        end
    endfunction

endpackage

[rtl/profile_tag_parse_hash.sv]
// ----------------------------------------------------------------------------
// profile_tag_parse_hash: hash and field parser for file|line|name tags
// ----------------------------------------------------------------------------
// usage:
//   the slave stream carries one tag byte per beat in s_axis_tdata[7:0],
//   with s_axis_tlast on the final byte of the tag
//   the master stream gives one beat per tag, after the tlast byte: the
//   65599 multiplicative hash of all bytes, the file-name length, the signed
//   line number, the name offset and name length; m_axis_tuser flags a tag
//   longer than MAX_LEN bytes
//   timing: a byte is registered on acceptance and then folded into the
//   running state; the result beat is registered when the tlast byte leaves
//   the byte register
//   throughput: one byte per cycle but for the stall below; the hash step is
//   a shift-and-add (h<<16 + h<<6 - h + byte), the line step a x10 one, both
//   combinational between the byte register and the state/result registers
//   stall: while a result beat waits, further bytes keep streaming into the
//   next tag; only a second tlast byte waits in the byte register, with
//   tready low, until the pending result is taken
//   reset: clears the running state and both valid flags; the next byte is
//   the first of a new tag
// ----------------------------------------------------------------------------
module profile_tag_parse_hash #(
    parameter int MAX_LEN = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // slave side
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ptph_pkg::CHAR_W-1:0]      s_axis_tdata,   // char_byte
    input  logic                             s_axis_tlast,   // is_last
    // master side
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tag_hash, file_len, line_value, name_offset, name_len, zero pad
    output logic [ptph_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tuser    // too_long
);
    import ptph_pkg::*;

    // byte count saturates at MAX_LEN+1
    localparam int PosW = $clog2(MAX_LEN + 2);
    localparam logic [PosW-1:0] PosSat = PosW'(MAX_LEN + 1);
    localparam logic [PosW-1:0] PosMax = PosW'(MAX_LEN);

    // byte register
    logic                 s1_valid_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic                 last_reg;
    logic                 s1_go;
    logic                 s1_fire;

    // running tag state
    logic [HASH_W-1:0]    hash_reg,        hash_next;
    logic [PosW-1:0]      pos_reg,         pos_next;
    logic                 first_pipe_reg,  first_pipe_next;
    logic [PosW-1:0]      file_len_reg,    file_len_next;
    logic [PosW-1:0]      name_start_reg,  name_start_next;
    logic [LINE_W-1:0]    line_accum_reg,  line_accum_next;
    line_phase_t          phase_reg,       phase_next;
    logic                 line_neg_reg,    line_neg_next;
    logic                 overflow_reg,    overflow_next;

    // result register
    logic                 m_valid_reg;
    result_t              result_reg,      result_next;
    logic                 too_long_reg;

    logic                 is_digit;
    logic [LINE_W-1:0]    digit_val;
    logic [LINE_W-1:0]    line_final;
    logic [PosW-1:0]      name_len_raw;

    // a tlast byte may only advance when the result register is free or being taken
    assign s1_go         = !last_reg || !m_valid_reg || m_axis_tready;
    assign s1_fire       = s1_valid_reg && s1_go;
    assign s_axis_tready = !s1_valid_reg || s1_go;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = result_reg;
    assign m_axis_tuser  = too_long_reg;

    // per-byte update of the running state
    always_comb
    begin
        hash_next       = hash_reg;
        pos_next        = pos_reg;
        first_pipe_next = first_pipe_reg;
        file_len_next   = file_len_reg;
        name_start_next = name_start_reg;
        line_accum_next = line_accum_reg;
        phase_next      = phase_reg;
        line_neg_next   = line_neg_reg;
        overflow_next   = overflow_reg;

        is_digit  = (char_reg >= DIGIT_0) && (char_reg <= DIGIT_9);
        digit_val = LINE_W'(char_reg - DIGIT_0);

        // line number parser on the bytes after the first pipe
        case (phase_reg)
            PH_SIGN:
            begin
                if (char_reg == MINUS_CHAR)
                begin
                    line_neg_next = 1'b1;
                    phase_next    = PH_DIGITS;
                end
                else if (is_digit)
                begin
                    line_accum_next = digit_val;
                    phase_next      = PH_DIGITS;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_DIGITS:
            begin
                if (is_digit)
                    line_accum_next = (line_accum_reg << 3) + (line_accum_reg << 1)
                                      + digit_val;
                else
                    phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        pos_next = (pos_reg < PosSat) ? pos_reg + 1'b1 : pos_reg;
        if (pos_next > PosMax)
            overflow_next = 1'b1;

        if (char_reg == PIPE_CHAR)
        begin
            if (!first_pipe_reg)
            begin
                first_pipe_next = 1'b1;
                file_len_next   = pos_reg;
                line_accum_next = '0;
                line_neg_next   = 1'b0;
                phase_next      = PH_SIGN;
            end
            else
            begin
                name_start_next = pos_next;
            end
        end

        // h * 65599 + byte, with 65599 = 2^16 + 2^6 - 1
        hash_next = (hash_reg << 16) + (hash_reg << 6) - hash_reg
                    + HASH_W'(char_reg);

        // result fields from the updated state
        line_final   = line_neg_next ? (LINE_W'(0) - line_accum_next) : line_accum_next;
        name_len_raw = (pos_next >= name_start_next) ? (pos_next - name_start_next)
                                                     : '0;

        result_next             = '0;
        result_next.tag_hash    = hash_next;
        result_next.file_len    = clamp12(32'(file_len_next));
        result_next.line_value  = line_final;
        result_next.name_offset = clamp12(32'(name_start_next));
        result_next.name_len    = clamp12(32'(name_len_raw));
    end

    // byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_axis_tready)
            s1_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            char_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
    end

    // running state, cleared after the tlast byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg       <= '0;
            pos_reg        <= '0;
            first_pipe_reg <= 1'b0;
            file_len_reg   <= '0;
            name_start_reg <= '0;
            line_accum_reg <= '0;
            phase_reg      <= PH_IDLE;
            line_neg_reg   <= 1'b0;
            overflow_reg   <= 1'b0;
        end
        else if (s1_fire)
        begin
            if (last_reg)
            begin
                hash_reg       <= '0;
                pos_reg        <= '0;
                first_pipe_reg <= 1'b0;
                file_len_reg   <= '0;
                name_start_reg <= '0;
                line_accum_reg <= '0;
                phase_reg      <= PH_IDLE;
                line_neg_reg   <= 1'b0;
                overflow_reg   <= 1'b0;
            end
            else
            begin
                hash_reg       <= hash_next;
                pos_reg        <= pos_next;
                first_pipe_reg <= first_pipe_next;
                file_len_reg   <= file_len_next;
                name_start_reg <= name_start_next;
                line_accum_reg <= line_accum_next;
                phase_reg      <= phase_next;
                line_neg_reg   <= line_neg_next;
                overflow_reg   <= overflow_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (s1_fire && last_reg)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && last_reg)
        begin
            result_reg   <= result_next;
            too_long_reg <= overflow_next;
        end
    end

endmodule

[sim/profile_tag_parse_hash_tb.sv]
// ----------------------------------------------------------------------------
// profile_tag_parse_hash_tb: self-checking bench for the tag hash and parser
// streams file|line|name tags byte by byte into the block, predicts the
// hash, lengths, line number and too-long flag of every tag, and compares
// each result beat against the oldest prediction; both stream sides idle
// and stall at random
// ----------------------------------------------------------------------------
module profile_tag_parse_hash_tb;

    import ptph_pkg::*;

    localparam int          TAG_MAX     = 4096;        // longest tag without the flag
    localparam logic [31:0] HASH_MUL    = 32'd65599;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          TAIL_CYCLES = 32;          // extra wait before the verdict
    localparam int          HOLD_AT     = 40;          // results before the long receiver hold
    localparam int          HOLD_CYCLES = 400;
    localparam int          RAND_BYTES  = 1350;

    // one pending slave beat; a drain entry makes the sender wait for all results
    typedef struct {
        logic [CHAR_W-1:0] data;
        logic              last;
        bit                drain;
    } tag_beat_t;

    // what one tag should produce
    typedef struct {
        logic [HASH_W-1:0]        hash;
        logic [FIELD12_W-1:0]     file_len;
        logic signed [LINE_W-1:0] line;
        logic [FIELD12_W-1:0]     name_off;
        logic [FIELD12_W-1:0]     name_len;
        logic                     too_long;
    } tag_result_t;

    typedef logic [CHAR_W-1:0] char_q_t[$];

    // receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE
    } rx_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [CHAR_W-1:0]      s_axis_tdata = '0;    // char_byte
    logic                   s_axis_tlast = 1'b0;  // is_last
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;         // hash, file_len, line, name_offset, name_len
    logic                   m_axis_tuser;         // too_long

    tag_beat_t   tag_bytes[$];      // beats still to be offered
    tag_result_t results_due[$];    // predicted results not yet seen

    int fail_count   = 0;
    int results_seen = 0;
    int cycle_count  = 0;

    // running copy of the parser state
    logic [HASH_W-1:0]  run_hash;
    int unsigned        byte_pos;
    bit                 pipe_seen;
    int unsigned        file_len_cnt;
    int unsigned        name_start_cnt;
    logic [LINE_W-1:0]  line_acc;
    line_phase_t        line_phase;
    bit                 line_neg;
    bit                 long_flag;

    profile_tag_parse_hash #(
        .MAX_LEN(TAG_MAX)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    function automatic void clear_tag_state();
        run_hash       = '0;
        byte_pos       = 0;
        pipe_seen      = 1'b0;
        file_len_cnt   = 0;
        name_start_cnt = 0;
        line_acc       = '0;
        line_phase     = PH_IDLE;
        line_neg       = 1'b0;
        long_flag      = 1'b0;
    endfunction

    // counts that do not fit the 12-bit fields stick at all ones
    function automatic logic [FIELD12_W-1:0] sat12(input int unsigned v);
        return (v > FIELD12_MAX) ? FIELD12_MAX[FIELD12_W-1:0] : v[FIELD12_W-1:0];
    endfunction

    // fold one accepted byte into the tag state; the tlast byte yields a result
    function automatic void fold_tag_byte(input logic [CHAR_W-1:0] c, input logic last);
        int unsigned idx;
        int unsigned nxt;
        int unsigned nlen;
        bit          digit;
        tag_result_t res;
        idx   = byte_pos;
        digit = (c >= DIGIT_0) && (c <= DIGIT_9);

        // line number parser runs on the bytes after the first pipe
        case (line_phase)
            PH_SIGN:
            begin
                if (c == MINUS_CHAR)
                begin
                    line_neg   = 1'b1;
                    line_phase = PH_DIGITS;
                end
                else if (digit)
                begin
                    line_acc   = LINE_W'(c - DIGIT_0);
                    line_phase = PH_DIGITS;
                end
                else
                    line_phase = PH_DONE;
            end
            PH_DIGITS:
            begin
                if (digit)
                    line_acc = line_acc * 10 + LINE_W'(c - DIGIT_0);
                else
                    line_phase = PH_DONE;
            end
            default: ;
        endcase

        // byte count saturates one past the limit
        nxt = (idx < TAG_MAX + 1) ? idx + 1 : idx;
        if (nxt > TAG_MAX)
            long_flag = 1'b1;

        if (c == PIPE_CHAR)
        begin
            if (!pipe_seen)
            begin
                pipe_seen    = 1'b1;
                file_len_cnt = idx;
                line_acc     = '0;
                line_neg     = 1'b0;
                line_phase   = PH_SIGN;
            end
            else
                name_start_cnt = nxt;
        end

        run_hash = run_hash * HASH_MUL + HASH_W'(c);
        byte_pos = nxt;

        if (last)
        begin
            nlen         = (byte_pos >= name_start_cnt) ? byte_pos - name_start_cnt : 0;
            res.hash     = run_hash;
            res.file_len = sat12(file_len_cnt);
            res.line     = line_neg ? -line_acc : line_acc;
            res.name_off = sat12(name_start_cnt);
            res.name_len = sat12(nlen);
            res.too_long = long_flag;
            results_due.push_back(res);
            clear_tag_state();
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------------

    function automatic logic [CHAR_W-1:0] plain_byte();
        logic [CHAR_W-1:0] v;
        do
            v = 8'($urandom_range(0, 255));
        while (v == PIPE_CHAR);
        return v;
    endfunction

    task automatic push_tag(input char_q_t t);
        tag_beat_t b;
        foreach (t[i])
        begin
            b.data  = t[i];
            b.last  = (i == t.size() - 1);
            b.drain = 1'b0;
            tag_bytes.push_back(b);
        end
    endtask

    task automatic push_text(input string s);
        char_q_t t;
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
        push_tag(t);
    endtask

    task automatic push_drain();
        tag_beat_t b;
        b.data  = '0;
        b.last  = 1'b0;
        b.drain = 1'b1;
        tag_bytes.push_back(b);
    endtask

    // mostly file|line|name with random content, the rest raw noise
    task automatic push_random_tag();
        char_q_t t;
        int      n;
        if ($urandom_range(0, 4) != 0)
        begin
            n = $urandom_range(0, 10);
            repeat (n) t.push_back(plain_byte());
            t.push_back(PIPE_CHAR);
            if ($urandom_range(0, 2) == 0)
                t.push_back(MINUS_CHAR);
            n = $urandom_range(0, 12);      // long runs wrap the line number
            repeat (n) t.push_back(8'(DIGIT_0 + $urandom_range(0, 9)));
            if ($urandom_range(0, 3) == 0)
                t.push_back(plain_byte());
            n = $urandom_range(0, 9);
            repeat (n)
            begin
                // extra pipes move the name start; sometimes none at all
                if ($urandom_range(0, 2) == 0)
                    t.push_back(PIPE_CHAR);
                else
                    t.push_back(plain_byte());
            end
            if ($urandom_range(0, 9) != 0)
                t.push_back(PIPE_CHAR);
            n = $urandom_range(0, 10);
            repeat (n) t.push_back(plain_byte());
            if (t.size() == 0)
                t.push_back(plain_byte());
        end
        else
        begin
            n = $urandom_range(1, 20);
            repeat (n)
            begin
                case ($urandom_range(0, 5))
                    0:       t.push_back(PIPE_CHAR);
                    1:       t.push_back(MINUS_CHAR);
                    2:       t.push_back(8'(DIGIT_0 + $urandom_range(0, 9)));
                    default: t.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
        push_tag(t);
    endtask

    // ------------------------------------------------------------------------
    // sender: bursts of random length with random gaps, holds a beat until taken
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                fold_tag_byte(s_axis_tdata, s_axis_tlast);
                void'(tag_bytes.pop_front());
            end
            // a new offer only once the current beat is gone
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (tag_bytes.size() != 0 && tag_bytes[0].drain)
                begin
                    // pause until every predicted result has come back
                    if (results_due.size() == 0)
                        void'(tag_bytes.pop_front());
                    s_axis_tvalid <= 1'b0;
                end
                else if (tag_bytes.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= tag_bytes[0].data;
                    s_axis_tlast  <= tag_bytes[0].last;
                    if (burst_left != 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: stall pattern switches now and then, plus one long hold so the
    // block has to stop taking bytes
    // ------------------------------------------------------------------------
    rx_mode_t rx_mode   = RX_OPEN;
    int       rx_left   = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = rx_mode_t'($urandom_range(0, 2));
                    rx_left = $urandom_range(8, 64);
                end
                else
                    rx_left--;
                case (rx_mode)
                    RX_OPEN:  m_axis_tready <= 1'b1;
                    RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
                    default:  m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: every result beat against the oldest prediction
    // ------------------------------------------------------------------------

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t     beat;
        tag_result_t due;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beat = m_axis_tdata;
            results_seen++;
            if (results_due.size() == 0)
            begin
                $display("%0t: result beat with no tag pending, expected none, actual hash %h",
                         $time, beat.tag_hash);
                fail_count++;
            end
            else
            begin
                due = results_due.pop_front();
                check_field("tag_hash",    due.hash,            beat.tag_hash);
                check_field("file_len",    32'(due.file_len),   32'(beat.file_len));
                check_field("line_value",  due.line,            beat.line_value);
                check_field("name_offset", 32'(due.name_off),   32'(beat.name_offset));
                check_field("name_len",    32'(due.name_len),   32'(beat.name_len));
                check_field("too_long",    32'(due.too_long),   32'(m_axis_tuser));
            end
        end
    end

    // hard stop if the stream hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        clear_tag_state();

        // directed: extreme bytes as one-byte tags, a full tag, plus sign,
        // empty file and name, minus with no digits, line number wrap
        push_tag({8'h00});
        push_tag({8'hFF});
        push_text("ab|-7|c|d");
        push_text("|+3||");
        push_text("|-|");
        push_text("|99999999999");

        // random tags, with two pauses for every result to come back
        while (tag_bytes.size() < RAND_BYTES / 3)
            push_random_tag();
        push_drain();
        while (tag_bytes.size() < 2 * RAND_BYTES / 3)
            push_random_tag();
        push_drain();
        while (tag_bytes.size() < RAND_BYTES)
            push_random_tag();

        repeat (10) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (tag_bytes.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && results_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
